@@ design/ecgpk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgpk_pkg
// Shared widths, register indexes and types for the ECG peak detector.
// ----------------------------------------------------------------------------
package ecgpk_pkg;

	localparam int SampleBits = 16;
	localparam int TimerBits  = 9;
	localparam int TimeoutBits = 8;
	localparam int BlankBits  = 8;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 16;

	localparam logic [TimerBits-1:0]  TimerMax    = '1;
	localparam logic [SampleBits-1:0] MaxArmLevel = SampleBits'(2);

	typedef logic [SampleBits-1:0]  sample_t;
	typedef logic [TimerBits-1:0]   timer_t;
	typedef logic [TimeoutBits-1:0] timeout_t;
	typedef logic [BlankBits-1:0]   blank_t;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_PEAK_TIMEOUT = 2'd0,
		REG_MIN_PEAK     = 2'd1,
		REG_BLANK_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		timeout_t peak_timeout;
		sample_t  min_peak_amplitude;
		blank_t   blank_length;
	} cfg_t;

endpackage
`default_nettype wire

@@ design/ecgpk_detect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgpk_detect
// Rising-maximum tracker; confirms a peak on half-drop or timeout.
// ----------------------------------------------------------------------------
module ecgpk_detect (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire ecgpk_pkg::sample_t  sample,
	input  wire ecgpk_pkg::cfg_t     cfg,
	output ecgpk_pkg::sample_t       raw_peak
);
	import ecgpk_pkg::*;

	sample_t prev_q;
	sample_t max_q;
	timer_t  tsm_q;

	timer_t  t_inc;
	timer_t  t_next;
	sample_t mx_next;
	sample_t pk;
	logic    rising;
	logic    confirm;

	always_comb begin
		t_inc = tsm_q;
		if (tsm_q != '0 && tsm_q != TimerMax) begin
			t_inc = tsm_q + TimerBits'(1);
		end
		rising  = (sample > prev_q) && (sample > max_q);
		confirm = (sample < {1'b0, max_q[SampleBits-1:1]}) ||
			(t_inc > {1'b0, cfg.peak_timeout});
		t_next  = t_inc;
		mx_next = max_q;
		pk      = '0;
		if (confirm) begin
			pk      = max_q;
			mx_next = '0;
			t_next  = '0;
		end
		if (rising) begin
			mx_next = sample;
			if (sample > MaxArmLevel) begin
				t_next = TimerBits'(1);
			end
		end
		if (rising || pk < cfg.min_peak_amplitude) begin
			pk = '0;
		end
	end

	assign raw_peak = pk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			max_q  <= '0;
			tsm_q  <= '0;
		end else if (step) begin
			prev_q <= sample;
			max_q  <= mx_next;
			tsm_q  <= t_next;
		end
	end

endmodule
`default_nettype wire

@@ design/ecgpk_blank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgpk_blank
// Pre-blanking: hold the largest peak in a window, release it on expiry.
// ----------------------------------------------------------------------------
module ecgpk_blank (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire ecgpk_pkg::sample_t  raw_peak,
	input  wire ecgpk_pkg::blank_t   blank_length,
	output ecgpk_pkg::sample_t       verified_peak
);
	import ecgpk_pkg::*;

	sample_t cand_q;
	blank_t  count_q;

	sample_t cand_next;
	blank_t  count_next;
	sample_t out_val;
	logic    dec;

	always_comb begin
		cand_next  = cand_q;
		count_next = count_q;
		out_val    = '0;
		dec        = 1'b0;
		if (raw_peak != '0 && count_q == '0) begin
			cand_next  = raw_peak;
			count_next = blank_length;
		end else if (raw_peak == '0 && count_q != '0) begin
			dec = 1'b1;
		end else if (raw_peak != '0) begin
			if (raw_peak > cand_q) begin
				cand_next  = raw_peak;
				count_next = blank_length;
			end else begin
				dec = 1'b1;
			end
		end
		if (dec) begin
			count_next = count_q - BlankBits'(1);
			if (count_q == BlankBits'(1)) begin
				out_val = cand_q;
			end
		end
	end

	assign verified_peak = out_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			cand_q  <= cand_next;
			count_q <= count_next;
		end
	end

endmodule
`default_nettype wire

@@ design/ecg_peak_detector_preblank_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_peak_detector_preblank_unit
// Streaming ECG peak detector with pre-blanking of candidate peaks.
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out (raw and verified peak).
// A sample is accepted whenever the input register is empty or advancing: it lands
// in the input register, then the detector and blanking state update as the
// result is loaded into the output register. Sustained rate is one sample per
// cycle while m_axis_tready does not stall the output; that rate is set by the state update loop.
// Configuration writes take effect at once and are meant for idle periods.
module ecg_peak_detector_preblank_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [15:0]                   s_axis_tdata,  // [15:0] sample
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [15:0] raw_peak, [31:16] verified_peak
	input  wire logic                          cfg_wr_en,
	input  wire logic [ecgpk_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire logic [ecgpk_pkg::CfgDataBits-1:0] cfg_wdata
);
	import ecgpk_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	sample_t sample_s1;
	logic    advance;
	sample_t raw_peak;
	sample_t verified_peak;
	sample_t raw_q;
	sample_t ver_q;
	logic    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_timeout       <= TimeoutBits'(19);
			cfg_q.min_peak_amplitude <= SampleBits'(7);
			cfg_q.blank_length       <= BlankBits'(40);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PEAK_TIMEOUT: cfg_q.peak_timeout       <= cfg_wdata[TimeoutBits-1:0];
				REG_MIN_PEAK:     cfg_q.min_peak_amplitude <= cfg_wdata[SampleBits-1:0];
				REG_BLANK_LENGTH: cfg_q.blank_length       <= cfg_wdata[BlankBits-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata[SampleBits-1:0];
		end
	end

	ecgpk_detect u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.sample   (sample_s1),
		.cfg      (cfg_q),
		.raw_peak (raw_peak)
	);

	ecgpk_blank u_blank (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.raw_peak      (raw_peak),
		.blank_length  (cfg_q.blank_length),
		.verified_peak (verified_peak)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			raw_q <= raw_peak;
			ver_q <= verified_peak;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {ver_q, raw_q};

endmodule
`default_nettype wire
